/* src/deq_pkg.sv */
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue unit.
// ---------------------------------------------------------------------------
package deq_pkg;

    // Storage geometry
    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    // Operation codes carried in the input tuser
    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_LIST       = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_POP_BACK   = 3'd4
    } t_op;

    // Result status carried in the output tuser
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // What a storage cell does this cycle
    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_SHR,   // take left neighbor
        CELL_SHL,   // take right neighbor
        CELL_LOAD,  // take input word
        CELL_WRAP   // take head cell (list rotation)
    } t_cell_op;

    // Control FSM
    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } t_state;

endpackage

/* src/double_ended_queue_unit.sv */
// ---------------------------------------------------------------------------
// double_ended_queue_unit
// Bounded double-ended queue of signed 32-bit words held in a chain of cells.
// ---------------------------------------------------------------------------
// Usage:
//   Input stream: s_tuser = operation (push front, push back, list,
//   pop front, pop back), s_tdata = word to push. Output stream:
//   m_tdata = popped or listed word (zero otherwise), m_tuser = status
//   (ok, empty, full), m_tlast = final result of the operation.
//   The front of the queue always sits in cell 0: push front and pop front
//   shift the whole chain one cell, push back writes only the cell at the
//   current count, and pop back reads cell count-1 and moves no cell.
//   Push and pop give one result in the cycle after acceptance; with the
//   output drained a new operation is taken every cycle.
//   List streams count words, one per cycle while the output is drained,
//   by rotating the occupied part of the chain through cell 0; s_tready
//   stays low while the list runs, and the chain ends in its original
//   order. An empty list gives one empty result.
//   Unused operation codes are accepted and give no result.
//   Reset clears the count (queue empty); cell contents are not cleared.
//   When m_tready is low the result is held in the output register, and a
//   new operation is taken only once that register is free.
// ---------------------------------------------------------------------------
module double_ended_queue_unit (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_tvalid,
    output logic                        o_s_tready,
    input  logic [deq_pkg::DATA_W-1:0]  i_s_tdata,   // [31:0] value_in
    input  logic [2:0]                  i_s_tuser,   // [2:0] operation
    output logic                        o_m_tvalid,
    input  logic                        i_m_tready,
    output logic [deq_pkg::DATA_W-1:0]  o_m_tdata,   // [31:0] value_out
    output logic [1:0]                  o_m_tuser,   // [1:0] status
    output logic                        o_m_tlast    // last_of_run
);
    import deq_pkg::*;

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [CNT_W-1:0]  r_left,  n_left;
    logic              r_ovalid, n_ovalid;
    logic [DATA_W-1:0] r_odata, n_odata;
    t_status           r_ostat, n_ostat;
    logic              r_olast, n_olast;

    t_cell_op          w_cop   [CAPACITY];
    logic [DATA_W-1:0] w_val   [CAPACITY];
    logic [DATA_W-1:0] w_lnb   [CAPACITY];
    logic [DATA_W-1:0] w_rnb   [CAPACITY];
    logic [DATA_W-1:0] w_tail;
    logic              w_slot_free;
    logic              w_s_fire;
    logic              w_full;
    logic              w_empty;

    assign w_slot_free = !r_ovalid || i_m_tready;
    assign o_s_tready  = (r_state == S_IDLE) && w_slot_free;
    assign w_s_fire    = i_s_tvalid && o_s_tready;
    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_empty     = (r_count == '0);

    // cell chain
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        if (g == 0) begin : g_first
            assign w_lnb[g] = i_s_tdata;
        end else begin : g_mid
            assign w_lnb[g] = w_val[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign w_rnb[g] = w_val[g];
        end else begin : g_inner
            assign w_rnb[g] = w_val[g+1];
        end

        deq_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_cop[g]),
            .i_left  (w_lnb[g]),
            .i_right (w_rnb[g]),
            .i_in    (i_s_tdata),
            .i_head  (w_val[0]),
            .o_val   (w_val[g])
        );
    end

    // tail word: OR of the cell at count-1
    always_comb begin
        w_tail = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (CNT_W'(i + 1) == r_count) begin
                w_tail = w_tail | w_val[i];
            end
        end
    end

    // next state, cell controls, result
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_ovalid = r_ovalid && !i_m_tready;
        n_odata  = r_odata;
        n_ostat  = r_ostat;
        n_olast  = r_olast;
        for (int i = 0; i < CAPACITY; i++) begin
            w_cop[i] = CELL_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_s_fire) begin
                    case (i_s_tuser)
                        OP_PUSH_FRONT, OP_PUSH_BACK: begin
                            n_ovalid = 1'b1;
                            n_odata  = '0;
                            n_olast  = 1'b1;
                            if (w_full) begin
                                n_ostat = ST_FULL;
                            end else begin
                                n_ostat = ST_OK;
                                n_count = r_count + 1'b1;
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (i_s_tuser == OP_PUSH_FRONT) begin
                                        w_cop[i] = (i == 0) ? CELL_LOAD : CELL_SHR;
                                    end else if (CNT_W'(i) == r_count) begin
                                        w_cop[i] = CELL_LOAD;
                                    end
                                end
                            end
                        end
                        OP_POP_FRONT, OP_POP_BACK: begin
                            n_ovalid = 1'b1;
                            n_olast  = 1'b1;
                            if (w_empty) begin
                                n_odata = '0;
                                n_ostat = ST_EMPTY;
                            end else begin
                                n_ostat = ST_OK;
                                n_count = r_count - 1'b1;
                                if (i_s_tuser == OP_POP_FRONT) begin
                                    n_odata = w_val[0];
                                    for (int i = 0; i < CAPACITY; i++) begin
                                        w_cop[i] = CELL_SHL;
                                    end
                                end else begin
                                    n_odata = w_tail;
                                end
                            end
                        end
                        OP_LIST: begin
                            if (w_empty) begin
                                n_ovalid = 1'b1;
                                n_odata  = '0;
                                n_ostat  = ST_EMPTY;
                                n_olast  = 1'b1;
                            end else begin
                                n_left  = r_count;
                                n_state = S_LIST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_LIST: begin
                // emit head, rotate occupied cells left by one
                if (w_slot_free) begin
                    n_ovalid = 1'b1;
                    n_odata  = w_val[0];
                    n_ostat  = ST_OK;
                    n_olast  = (r_left == CNT_W'(1));
                    n_left   = r_left - 1'b1;
                    for (int i = 0; i < CAPACITY; i++) begin
                        if (CNT_W'(i + 1) == r_count) begin
                            w_cop[i] = CELL_WRAP;
                        end else if (CNT_W'(i + 1) < r_count) begin
                            w_cop[i] = CELL_SHL;
                        end
                    end
                    if (r_left == CNT_W'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_ovalid <= n_ovalid;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        r_odata <= n_odata;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = r_odata;
    assign o_m_tuser  = r_ostat;
    assign o_m_tlast  = r_olast;

    // count never exceeds capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count above capacity");

    // list walk stays within the stored entries
    a_list_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |-> (r_left != '0) && (r_left <= r_count))
        else $error("list counter out of range");

    // push at capacity gives a full status and leaves the count alone
    a_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && w_full &&
         (i_s_tuser == OP_PUSH_FRONT || i_s_tuser == OP_PUSH_BACK))
        |=> (r_ovalid && r_ostat == ST_FULL && r_count == $past(r_count)))
        else $error("push at capacity not refused");

    // pop from empty queue reports empty
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_s_fire && w_empty &&
         (i_s_tuser == OP_POP_FRONT || i_s_tuser == OP_POP_BACK))
        |=> (r_ovalid && r_ostat == ST_EMPTY && r_count == '0))
        else $error("pop on empty queue not reported");

    // list does not change the count
    a_list_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LIST) |=> (r_count == $past(r_count)))
        else $error("count changed during list");

endmodule

/* src/deq_cell.sv */
// ---------------------------------------------------------------------------
// deq_cell
// One storage slot of the queue chain; loads from a neighbor, the input
// word or the head cell as directed.
// ---------------------------------------------------------------------------
module deq_cell (
    input  logic                      i_clk,
    input  deq_pkg::t_cell_op         i_op,
    input  logic [deq_pkg::DATA_W-1:0] i_left,
    input  logic [deq_pkg::DATA_W-1:0] i_right,
    input  logic [deq_pkg::DATA_W-1:0] i_in,
    input  logic [deq_pkg::DATA_W-1:0] i_head,
    output logic [deq_pkg::DATA_W-1:0] o_val
);
    import deq_pkg::*;

    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] n_val;

    // next value select
    always_comb begin
        case (i_op)
            CELL_SHR:  n_val = i_left;
            CELL_SHL:  n_val = i_right;
            CELL_LOAD: n_val = i_in;
            CELL_WRAP: n_val = i_head;
            default:   n_val = r_val;
        endcase
    end

    // payload register, no reset
    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end

    assign o_val = r_val;

endmodule
